// ===== hdl/csim_pkg.sv =====
// Shared types and constants for the cosine similarity threshold block.
// Used by csim_mac, csim_root and cosine_similarity_threshold_top.
// No dependencies.
`default_nettype none

package csim_pkg;

  localparam int ElemW = 16;
  localparam int DotW = 42;
  localparam int SqW = 41;
  localparam int CntW = 11;
  localparam int SimW = 16;
  localparam int MagW = 17;
  localparam int MaxLength = 1024;
  localparam int CountMax = 2047;
  localparam int D2W = 84;
  localparam int QsW = 82;
  localparam int RootW = 115;
  localparam int RootBits = 15;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_BELOW    = 2'd1,
    ST_ZERO     = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_VECTOR_LENGTH    = 1'b0,
    REG_ACCEPT_THRESHOLD = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_CHECK,
    S_ROOT,
    S_EMIT
  } top_state_t;

  typedef enum logic [2:0] {
    RS_IDLE,
    RS_SQD,
    RS_SQS,
    RS_TOP,
    RS_TA,
    RS_TB,
    RS_TC
  } root_state_t;

  typedef struct packed {
    logic start;
    logic add_en;
    logic clear;
  } mac_ctrl_t;

  typedef struct packed {
    logic            done;
    logic [MagW-1:0] mag;
  } root_stat_t;

endpackage

`default_nettype wire

// ===== hdl/csim_mac.sv =====
// Element accumulator: one shared signed multiplier forms q*s, q*q, s*s in turn.
// Depends on csim_pkg.
`default_nettype none

module csim_mac import csim_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire mac_ctrl_t               ctrl,
  input  wire logic signed [ElemW-1:0] query_element,
  input  wire logic signed [ElemW-1:0] stored_element,
  output logic                         busy,
  output logic        [DotW-1:0]       dot_sum,
  output logic        [SqW-1:0]        query_square_sum,
  output logic        [SqW-1:0]        stored_square_sum
);

  logic                    active;
  logic [1:0]              step;
  logic                    pend_valid;
  logic [1:0]              pend_dst;
  logic signed [ElemW-1:0] qr;
  logic signed [ElemW-1:0] sr;
  logic signed [ElemW-1:0] mul_a;
  logic signed [ElemW-1:0] mul_b;
  logic signed [2*ElemW-1:0] prod;

  // Pick operands for the shared multiplier
  always_comb begin
    unique case (step)
      2'd0: begin
        mul_a = qr;
        mul_b = sr;
      end
      2'd1: begin
        mul_a = qr;
        mul_b = qr;
      end
      default: begin
        mul_a = sr;
        mul_b = sr;
      end
    endcase
  end

  // Sequence the three products
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      pend_valid <= 1'b0;
      step       <= 2'd0;
    end else begin
      pend_valid <= active;
      if (ctrl.start) begin
        active <= 1'b1;
        step   <= 2'd0;
      end else if (active) begin
        step <= step + 2'd1;
        if (step == 2'd2) begin
          active <= 1'b0;
        end
      end
    end
  end

  // Hold operands and register each product
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      qr <= query_element;
      sr <= stored_element;
    end
    prod     <= mul_a * mul_b;
    pend_dst <= step;
  end

  // Add the registered product into its sum; sums wrap at their widths
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      dot_sum           <= '0;
      query_square_sum  <= '0;
      stored_square_sum <= '0;
    end else if (pend_valid && ctrl.add_en) begin
      case (pend_dst)
        2'd0: dot_sum <= dot_sum + {{(DotW-2*ElemW){prod[2*ElemW-1]}}, prod};
        2'd1: query_square_sum <= query_square_sum + {{(SqW-2*ElemW){1'b0}}, prod};
        default: stored_square_sum <= stored_square_sum + {{(SqW-2*ElemW){1'b0}}, prod};
      endcase
    end
  end

  assign busy = active | pend_valid;

endmodule

`default_nettype wire

// ===== hdl/csim_root.sv =====
// Similarity magnitude unit: one shared wide adder forms D*D and Q*S by shift-add,
// then finds the largest r with r*r*Q*S <= 2^30*D*D one bit at a time.
// Depends on csim_pkg.
`default_nettype none

module csim_root import csim_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [DotW-1:0] dot_sum,
  input  wire logic [SqW-1:0]  query_square_sum,
  input  wire logic [SqW-1:0]  stored_square_sum,
  output root_stat_t           stat
);

  root_state_t state;
  root_state_t state_next;

  logic [5:0]          cnt;
  logic [D2W-1:0]      acc;
  logic [D2W-1:0]      mcand;
  logic [DotW-1:0]     mplier;
  logic [D2W-1:0]      d2;
  logic [QsW-1:0]      qs;
  logic [RootW-1:0]    p;
  logic [RootW-1:0]    t;
  logic [RootW-1:0]    ash;
  logic [RootW-1:0]    termq;
  logic [RootBits-1:0] r;
  logic [3:0]          k;
  logic                fit;
  logic                fit_now;
  logic [RootW-1:0]    add_a;
  logic [RootW-1:0]    add_b;
  logic [RootW-1:0]    sum;
  logic [DotW-1:0]     dmag;

  assign dmag = dot_sum[DotW-1] ? (~dot_sum + 1'b1) : dot_sum;

  // Shared adder operand selection
  always_comb begin
    add_a = '0;
    add_b = '0;
    unique case (state)
      RS_SQD, RS_SQS: begin
        add_a = RootW'(acc);
        add_b = mplier[0] ? RootW'(mcand) : '0;
      end
      RS_TA: begin
        add_a = p;
        add_b = ash;
      end
      RS_TB: begin
        add_a = t;
        add_b = termq;
      end
      RS_TC: begin
        add_a = ash;
        add_b = fit ? (termq << 1) : '0;
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign sum     = add_a + add_b;
  assign fit_now = (sum <= {1'b0, d2, 30'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      RS_IDLE: if (start) state_next = RS_SQD;
      RS_SQD:  if (cnt == 6'(DotW-1)) state_next = RS_SQS;
      RS_SQS:  if (cnt == 6'(DotW-1)) state_next = RS_TOP;
      RS_TOP:  state_next = (RootW'(qs) <= RootW'(d2)) ? RS_IDLE : RS_TA;
      RS_TA:   state_next = RS_TB;
      RS_TB:   state_next = RS_TC;
      RS_TC:   state_next = (k == 4'd0) ? RS_IDLE : RS_TA;
      default: state_next = RS_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      case (state)
        RS_IDLE: begin
          if (start) begin
            acc    <= '0;
            mcand  <= D2W'(dmag);
            mplier <= dmag;
            cnt    <= '0;
          end
        end
        RS_SQD: begin
          acc    <= sum[D2W-1:0];
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt + 6'd1;
          if (cnt == 6'(DotW-1)) begin
            d2     <= sum[D2W-1:0];
            acc    <= '0;
            mcand  <= D2W'(query_square_sum);
            mplier <= DotW'(stored_square_sum);
            cnt    <= '0;
          end
        end
        RS_SQS: begin
          acc    <= sum[D2W-1:0];
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt + 6'd1;
          if (cnt == 6'(DotW-1)) begin
            qs <= sum[QsW-1:0];
          end
        end
        RS_TOP: begin
          if (RootW'(qs) <= RootW'(d2)) begin
            stat.mag  <= MagW'(1 << RootBits);
            stat.done <= 1'b1;
          end else begin
            p     <= '0;
            ash   <= '0;
            termq <= RootW'(qs) << (2 * (RootBits - 1));
            r     <= '0;
            k     <= 4'(RootBits - 1);
          end
        end
        RS_TA: begin
          t <= sum;
        end
        RS_TB: begin
          fit <= fit_now;
          if (fit_now) begin
            p    <= sum;
            r[k] <= 1'b1;
          end
        end
        RS_TC: begin
          ash   <= sum >> 1;
          termq <= termq >> 2;
          if (k == 4'd0) begin
            stat.mag  <= {2'b00, r};
            stat.done <= 1'b1;
          end else begin
            k <= k - 4'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cosine_similarity_threshold_top.sv =====
// Cosine similarity with acceptance threshold: top level with handshakes and control.
// Each element word is accepted, passes through the 3 shared multiplies and the last add, then
// returns to idle; the last word then goes through check, shift-add squaring, setup, the root
// search, taking the result and emit; a mismatch or zero length goes from check straight to emit.
// One word is worked on at a time; a finished result may wait while the next word enters.
// Synchronous reset clears sums, count and handshake state; vector_length = 384,
// accept_threshold = 11469.
`default_nettype none

module cosine_similarity_threshold_top import csim_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write,
  input  wire logic                    cfg_index,
  input  wire logic [SimW-1:0]         cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [ElemW-1:0] query_element,
  input  wire logic signed [ElemW-1:0] stored_element,
  input  wire logic [15:0]             vector_tag,
  input  wire logic                    last,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [15:0]                  result_tag,
  output logic signed [SimW-1:0]       similarity,
  output logic [1:0]                   status
);

  top_state_t state;
  top_state_t state_next;

  logic [CntW-1:0]        vector_length;
  logic signed [SimW-1:0] accept_threshold;
  logic [CntW-1:0]        element_count;
  logic [15:0]            tag;
  logic                   last_word;
  logic                   add_en;
  logic signed [SimW-1:0] res_sim;
  status_t                res_status;
  logic                   mac_busy;
  logic                   in_fire;
  logic                   emit;
  logic                   mismatch;
  logic                   zero_len;
  logic signed [SimW-1:0] sim_calc;
  logic [MagW-1:0]        neg_mag;
  mac_ctrl_t              mac_ctrl;
  root_stat_t             root_stat;
  logic [DotW-1:0]        dot_sum;
  logic [SqW-1:0]         query_square_sum;
  logic [SqW-1:0]         stored_square_sum;

  assign in_fire = in_valid && in_ready;
  assign emit    = (state == S_EMIT) && (!out_valid || out_ready);

  assign mac_ctrl.start  = in_fire;
  assign mac_ctrl.add_en = add_en;
  assign mac_ctrl.clear  = emit;

  csim_mac u_mac (
    .clk               (clk),
    .rst               (rst),
    .ctrl              (mac_ctrl),
    .query_element     (query_element),
    .stored_element    (stored_element),
    .busy              (mac_busy),
    .dot_sum           (dot_sum),
    .query_square_sum  (query_square_sum),
    .stored_square_sum (stored_square_sum)
  );

  csim_root u_root (
    .clk               (clk),
    .rst               (rst),
    .start             (state == S_CHECK && !mismatch && !zero_len),
    .dot_sum           (dot_sum),
    .query_square_sum  (query_square_sum),
    .stored_square_sum (stored_square_sum),
    .stat              (root_stat)
  );

  // Special cases of the finished vector
  assign mismatch = (element_count != vector_length) ||
                    ({1'b0, element_count} > 12'(MaxLength));
  assign zero_len = (query_square_sum == '0) || (stored_square_sum == '0);

  // Apply sign and saturate
  assign neg_mag  = ~root_stat.mag + 1'b1;
  always_comb begin
    if (dot_sum[DotW-1]) begin
      sim_calc = neg_mag[SimW-1:0];
    end else if (root_stat.mag > MagW'(32767)) begin
      sim_calc = 16'sd32767;
    end else begin
      sim_calc = root_stat.mag[SimW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and ready
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_MAC;
      end
      S_MAC: begin
        if (!mac_busy) state_next = last_word ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        state_next = (mismatch || zero_len) ? S_EMIT : S_ROOT;
      end
      S_ROOT: begin
        if (root_stat.done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length    <= CntW'(384);
      accept_threshold <= 16'sd11469;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_VECTOR_LENGTH:    vector_length <= cfg_data[CntW-1:0];
        REG_ACCEPT_THRESHOLD: accept_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Count words and hold the word's side information
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
    end else if (emit) begin
      element_count <= '0;
    end else if (in_fire && element_count != CntW'(CountMax)) begin
      element_count <= element_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tag       <= vector_tag;
      last_word <= last;
      add_en    <= ({1'b0, element_count} < 12'(MaxLength));
    end
    if (state == S_CHECK) begin
      res_sim    <= '0;
      res_status <= mismatch ? ST_MISMATCH : ST_ZERO;
    end
    if (state == S_ROOT && root_stat.done) begin
      res_sim    <= sim_calc;
      res_status <= (sim_calc >= accept_threshold) ? ST_ACCEPTED : ST_BELOW;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_tag <= tag;
      similarity <= res_sim;
      status     <= res_status;
    end
  end

endmodule

`default_nettype wire

// ===== test/cosine_similarity_threshold_top_tb.sv =====
// Self-checking testbench for cosine_similarity_threshold_top: directed table, then random vectors.
// Uses csim_pkg for status and register codes; predicts each result with its own score model.
`default_nettype none

module cosine_similarity_threshold_top_tb import csim_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;

  typedef struct {
    logic [15:0]        tag;
    logic signed [15:0] sim;
    status_t            st;
  } score_t;

  typedef struct {
    logic signed [15:0] q;
    logic signed [15:0] s;
    logic [15:0]        tag;
    bit                 lst;
    bit                 typed;
    logic signed [15:0] sim;
    status_t            st;
  } row_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_write;
  logic                    cfg_index;
  logic [SimW-1:0]         cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [ElemW-1:0] query_element;
  logic signed [ElemW-1:0] stored_element;
  logic [15:0]             vector_tag;
  logic                    last;
  logic                    out_valid;
  logic                    out_ready;
  logic [15:0]             result_tag;
  logic signed [SimW-1:0]  similarity;
  logic [1:0]              status;

  // predictor state and configuration
  logic [41:0]        dot_acc;
  logic [40:0]        qsq_acc;
  logic [40:0]        ssq_acc;
  logic [10:0]        elem_cnt;
  logic [10:0]        vec_len;
  logic signed [15:0] accept_thr;

  score_t pending_scores[$];
  int     errors;
  int     words_sent;
  int     results_seen;
  int     status_hits[4];
  int     send_idle;
  int     recv_idle;
  int     stall_cycles;

  cosine_similarity_threshold_top uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .query_element(query_element), .stored_element(stored_element),
    .vector_tag(vector_tag), .last(last),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_tag(result_tag), .similarity(similarity), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // largest r in [0, 32768] with r*r*Q*S <= 2^30*D*D
  function automatic logic [16:0] cos_magnitude(logic [41:0] dm, logic [40:0] qq,
                                                logic [40:0] ss);
    logic [127:0] rhs;
    logic [127:0] qs;
    logic [16:0]  lo;
    logic [16:0]  hi;
    logic [16:0]  mid;
    rhs = (128'(dm) * 128'(dm)) << 30;
    qs = 128'(qq) * 128'(ss);
    lo = 0;
    hi = 17'd32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (qs * (128'(mid) * 128'(mid)) <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // accumulate one word; on last, form the score and clear
  function automatic bit score_word(logic signed [15:0] q, logic signed [15:0] s,
                                    logic [15:0] tag, bit lst, output score_t sc);
    int          qi;
    int          si;
    int          m;
    bit          neg;
    logic [41:0] dm;
    qi = q;
    si = s;
    sc.tag = tag;
    sc.sim = 0;
    if (elem_cnt < MaxLength) begin
      dot_acc = dot_acc + 42'(qi * si);
      qsq_acc = qsq_acc + 41'(qi * qi);
      ssq_acc = ssq_acc + 41'(si * si);
    end
    if (elem_cnt < CountMax) elem_cnt = elem_cnt + 1;
    if (!lst) return 1'b0;
    if (elem_cnt != vec_len || elem_cnt > MaxLength) begin
      sc.st = ST_MISMATCH;
    end else if (qsq_acc == 0 || ssq_acc == 0) begin
      sc.st = ST_ZERO;
    end else begin
      neg = dot_acc[41];
      dm = neg ? -dot_acc : dot_acc;
      m = cos_magnitude(dm, qsq_acc, ssq_acc);
      if (neg) sc.sim = 16'(-m);
      else sc.sim = (m > 32767) ? 16'sd32767 : 16'(m);
      sc.st = (sc.sim >= accept_thr) ? ST_ACCEPTED : ST_BELOW;
    end
    dot_acc = 0;
    qsq_acc = 0;
    ssq_acc = 0;
    elem_cnt = 0;
    return 1'b1;
  endfunction

  // present one word, hold it until accepted, then on the last word queue the vector's score
  task automatic send_word(logic signed [15:0] q, logic signed [15:0] s, logic [15:0] tag,
                           bit lst, bit typed, logic signed [15:0] sim, status_t st);
    int     gap;
    score_t sc;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    query_element <= q;
    stored_element <= s;
    vector_tag <= tag;
    last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (score_word(q, s, tag, lst, sc)) begin
      if (typed) begin
        sc.sim = sim;
        sc.st = st;
      end
      pending_scores.insert(pending_scores.size(), sc);
    end
  endtask

  // write a register once every score has drained
  task automatic write_reg(reg_index_t idx, logic [15:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_scores.size() == 0);
    repeat (10) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_VECTOR_LENGTH) vec_len = val[10:0];
    else accept_thr = val;
  endtask

  function automatic logic signed [15:0] pick_elem();
    case ($urandom_range(9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return 16'($urandom_range(64)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  // random vectors: mostly the configured length if 1 to 64, some short or long; else 1 to 6 words
  task automatic run_vectors(int n_words);
    int                 sent;
    int                 len;
    int                 kind;
    logic signed [15:0] q;
    logic signed [15:0] s;
    sent = 0;
    while (sent < n_words) begin
      if (vec_len >= 1 && vec_len <= 64) begin
        if ($urandom_range(99) < 80) len = vec_len;
        else len = $urandom_range(vec_len + 3, 1);
      end else begin
        len = $urandom_range(6, 1);
      end
      kind = $urandom_range(5);
      for (int i = 0; i < len; i++) begin
        q = pick_elem();
        s = pick_elem();
        case (kind)
          1: s = clamp16(int'(q) + int'($urandom_range(200)) - 100);
          2: s = clamp16(-int'(q));
          3: if (len > 1 && i == 0) q = 0; else q = 0;
          4: begin
            q = 16'($urandom_range(16)) - 16'sd8;
            s = 16'($urandom_range(16)) - 16'sd8;
          end
          5: s = clamp16(int'(q) / 2 + int'($urandom_range(4000)) - 2000);
          default: ;
        endcase
        send_word(q, s, 16'($urandom), i == len - 1, 1'b0, 0, ST_ACCEPTED);
      end
      sent += len;
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // compare each delivered result with the oldest score
  always @(posedge clk) begin
    score_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      status_hits[status]++;
      if (pending_scores.size() == 0) begin
        $display("%0t: unexpected result tag=%h sim=%0d status=%0d",
                 $time, result_tag, similarity, status);
        errors++;
      end else begin
        want = pending_scores.pop_front();
        if (result_tag !== want.tag) begin
          $display("%0t: tag expected %h actual %h", $time, want.tag, result_tag);
          errors++;
        end
        if (similarity !== want.sim) begin
          $display("%0t: similarity expected %0d actual %0d", $time, want.sim, similarity);
          errors++;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no word, result or write
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write || rst) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("cosine_similarity_threshold_top_tb failed");
        $finish;
      end
    end
  end

  row_t rows[] = '{
    '{16'sd32767, 16'sd32767, 16'h0000, 1'b1, 1'b1, 16'sd32767, ST_ACCEPTED},
    '{-16'sd32768, -16'sd32768, 16'hFFFF, 1'b1, 1'b1, 16'sd32767, ST_ACCEPTED},
    '{-16'sd32768, 16'sd32767, 16'h1234, 1'b1, 1'b1, -16'sd32768, ST_BELOW},
    '{16'sd0, 16'sd12, 16'hA5A5, 1'b1, 1'b1, 16'sd0, ST_ZERO},
    '{-16'sd7, 16'sd0, 16'h5A5A, 1'b1, 1'b1, 16'sd0, ST_ZERO},
    '{16'sd0, 16'sd0, 16'h0F0F, 1'b1, 1'b1, 16'sd0, ST_ZERO},
    '{16'sd1, -16'sd1, 16'hF0F0, 1'b1, 1'b1, -16'sd32768, ST_BELOW},
    '{16'sd21845, -16'sd1, 16'h00FF, 1'b1, 1'b1, -16'sd32768, ST_BELOW},
    '{16'sd100, 16'sd200, 16'h1111, 1'b0, 1'b0, 16'sd0, ST_ACCEPTED},
    '{16'sd300, -16'sd5, 16'h2222, 1'b1, 1'b1, 16'sd0, ST_MISMATCH},
    '{16'sd5, 16'sd9, 16'h3333, 1'b0, 1'b0, 16'sd0, ST_ACCEPTED},
    '{-16'sd4, 16'sd2, 16'h4444, 1'b0, 1'b0, 16'sd0, ST_ACCEPTED},
    '{16'sd8, 16'sd8, 16'h5555, 1'b1, 1'b1, 16'sd0, ST_MISMATCH},
    '{16'sd3, 16'sd1, 16'h6666, 1'b1, 1'b1, 16'sd32767, ST_ACCEPTED},
    '{16'sd12000, 16'sd12000, 16'h7777, 1'b1, 1'b1, 16'sd32767, ST_ACCEPTED}
  };

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_VECTOR_LENGTH;
    cfg_data = '0;
    in_valid = 1'b0;
    query_element = '0;
    stored_element = '0;
    vector_tag = '0;
    last = 1'b0;
    words_sent = 0;
    send_idle = 23;
    recv_idle = 65;
    dot_acc = 0;
    qsq_acc = 0;
    ssq_acc = 0;
    elem_cnt = 0;
    vec_len = 11'd384;
    accept_thr = 16'sd11469;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset length of 384 rejects a single word
    send_word(16'sd5, 16'sd5, 16'hBEEF, 1'b1, 1'b1, 16'sd0, ST_MISMATCH);

    // directed table at length one; its multi-word vectors expect a mismatch
    write_reg(REG_VECTOR_LENGTH, 16'd1);
    foreach (rows[i])
      send_word(rows[i].q, rows[i].s, rows[i].tag, rows[i].lst, rows[i].typed,
                rows[i].sim, rows[i].st);

    // random phases over several settings
    write_reg(REG_VECTOR_LENGTH, 16'd3);
    write_reg(REG_ACCEPT_THRESHOLD, 16'd0);
    run_vectors(200);
    write_reg(REG_VECTOR_LENGTH, 16'hF805);
    write_reg(REG_ACCEPT_THRESHOLD, 16'h8000);
    run_vectors(180);
    send_idle = 65;
    recv_idle = 23;
    write_reg(REG_VECTOR_LENGTH, 16'd1);
    write_reg(REG_ACCEPT_THRESHOLD, 16'h7FFF);
    run_vectors(120);
    write_reg(REG_VECTOR_LENGTH, 16'd8);
    write_reg(REG_ACCEPT_THRESHOLD, 16'd11469);
    run_vectors(250);
    send_idle = 0;
    recv_idle = 0;
    write_reg(REG_VECTOR_LENGTH, 16'd0);
    write_reg(REG_ACCEPT_THRESHOLD, 16'($urandom));
    run_vectors(40);
    write_reg(REG_VECTOR_LENGTH, 16'd2047);
    write_reg(REG_ACCEPT_THRESHOLD, 16'd100);
    run_vectors(40);
    write_reg(REG_VECTOR_LENGTH, 16'd12);
    write_reg(REG_ACCEPT_THRESHOLD, 16'($urandom));
    run_vectors(300);

    in_valid <= 1'b0;
    wait (pending_scores.size() == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d words, checked %0d results across nine register settings.",
             words_sent, results_seen);
    $display("Status counts: accepted %0d, below %0d, zero length %0d, mismatch %0d.",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
    if (errors == 0) begin
      $display("cosine_similarity_threshold_top_tb passed");
    end else begin
      $display("cosine_similarity_threshold_top_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
